[rtl/sit_pkg.sv]
// Shared widths, types and constants for the segment intersection test.
`timescale 1ns / 1ps
package sit_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 8;
  localparam int IN_W       = 16;
  localparam int OUT_W      = 32;

  localparam int AW  = COORD_BITS + 1;      // line coefficients A, B
  localparam int PW  = 2 * COORD_BITS;      // coordinate products
  localparam int CW2 = 2 * COORD_BITS + 1;  // coefficient C
  localparam int DW  = 2 * AW + 1;          // determinant
  localparam int DXW = AW + CW2 + 1;        // Dx, Dy
  localparam int NW  = DXW + 1;             // sign-normalized numerators, bound products
  localparam int QW  = NW + FRAC_BITS;      // dividend and quotient bits

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic signed [COORD_BITS-1:0] px;
    logic signed [COORD_BITS-1:0] py;
    logic signed [COORD_BITS-1:0] qx;
    logic signed [COORD_BITS-1:0] qy;
    logic signed [COORD_BITS-1:0] rx;
    logic signed [COORD_BITS-1:0] ry;
    logic signed [COORD_BITS-1:0] sx;
    logic signed [COORD_BITS-1:0] sy;
  } seg_t;

  // Classified pair handed from the front end to the divider back end.
  typedef struct packed {
    logic                 hit;
    logic                 parallel;
    logic signed [NW-1:0] num_x;
    logic signed [NW-1:0] num_y;
    logic [DW-1:0]        den;
  } mid_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

[rtl/sit_in_if.sv]
// Input channel: one segment pair per transaction.
`timescale 1ns / 1ps
interface sit_in_if import sit_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] first_start_x;
  logic signed [IN_W-1:0] first_start_y;
  logic signed [IN_W-1:0] first_end_x;
  logic signed [IN_W-1:0] first_end_y;
  logic signed [IN_W-1:0] second_start_x;
  logic signed [IN_W-1:0] second_start_y;
  logic signed [IN_W-1:0] second_end_x;
  logic signed [IN_W-1:0] second_end_y;

  modport source (
    output valid, first_start_x, first_start_y, first_end_x, first_end_y,
           second_start_x, second_start_y, second_end_x, second_end_y,
    input  ready
  );
  modport sink (
    input  valid, first_start_x, first_start_y, first_end_x, first_end_y,
           second_start_x, second_start_y, second_end_x, second_end_y,
    output ready
  );
endinterface

[rtl/sit_out_if.sv]
// Result channel: intersection verdict and crossing point per transaction.
`timescale 1ns / 1ps
interface sit_out_if import sit_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    hit;
  logic                    lines_parallel;
  logic signed [OUT_W-1:0] cross_x;
  logic signed [OUT_W-1:0] cross_y;
  logic                    point_saturated;

  modport source (
    output valid, hit, lines_parallel, cross_x, cross_y, point_saturated,
    input  ready
  );
  modport sink (
    input  valid, hit, lines_parallel, cross_x, cross_y, point_saturated,
    output ready
  );
endinterface

[rtl/sit_front.sv]
// Front end: line coefficients, Cramer determinants and exact bounding-box hit test; parallel pairs hit when collinear.
`timescale 1ns / 1ps
module sit_front import sit_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  sit_in_if.sink    in_seg,
  input  logic      q_full,
  output logic      q_push,
  output mid_t      q_data
);

  logic [6:0] vld_r;
  logic       adv;

  // stage 1
  seg_t                 c0;
  seg_t                 s1_r, s2_r, s3_r, s4_r;
  logic signed [AW-1:0] a1_1_r, b1_1_r, a2_1_r, b2_1_r;
  logic signed [PW-1:0] pp0_r, pp1_r, pp2_r, pp3_r;
  // stage 2
  logic signed [AW-1:0]  a1_2_r, b1_2_r, a2_2_r, b2_2_r;
  logic signed [CW2-1:0] c1_r, c2_r;
  // stage 3
  logic signed [2*AW-1:0]   m0_r, m1_r;
  logic signed [AW+CW2-1:0] m2_r, m3_r, m4_r, m5_r;
  // stage 4
  logic signed [DW-1:0]  d_r;
  logic signed [DXW-1:0] dx_r, dy_r;
  // stage 5
  logic                         neg;
  logic signed [NW-1:0]         dxw, dyw;
  logic signed [COORD_BITS-1:0] lo_c [4];
  logic signed [COORD_BITS-1:0] hi_c [4];
  logic signed [COORD_BITS-1:0] lo_r [4];
  logic signed [COORD_BITS-1:0] hi_r [4];
  logic signed [NW-1:0]         nx5_r, ny5_r;
  logic [DW-1:0]                den5_r;
  logic                         par5_r, coin5_r;
  // stage 6
  logic signed [DW:0]   dens;
  logic signed [NW-1:0] bl_r [4];
  logic signed [NW-1:0] bh_r [4];
  logic signed [NW-1:0] nx6_r, ny6_r;
  logic [DW-1:0]        den6_r;
  logic                 par6_r, coin6_r;
  // stage 7
  logic inbox;
  mid_t res_r;

  assign adv          = !vld_r[6] || !q_full;
  assign in_seg.ready = adv;
  assign q_push       = vld_r[6] && !q_full;
  assign q_data       = res_r;

  always_comb begin
    c0.px = in_seg.first_start_x[COORD_BITS-1:0];
    c0.py = in_seg.first_start_y[COORD_BITS-1:0];
    c0.qx = in_seg.first_end_x[COORD_BITS-1:0];
    c0.qy = in_seg.first_end_y[COORD_BITS-1:0];
    c0.rx = in_seg.second_start_x[COORD_BITS-1:0];
    c0.ry = in_seg.second_start_y[COORD_BITS-1:0];
    c0.sx = in_seg.second_end_x[COORD_BITS-1:0];
    c0.sy = in_seg.second_end_y[COORD_BITS-1:0];
  end

  // Sign normalization so the determinant is non-negative, and box corners.
  always_comb begin
    neg = d_r < 0;
    dxw = NW'(dx_r);
    dyw = NW'(dy_r);
    lo_c[0] = (s4_r.px < s4_r.qx) ? s4_r.px : s4_r.qx;
    hi_c[0] = (s4_r.px < s4_r.qx) ? s4_r.qx : s4_r.px;
    lo_c[1] = (s4_r.py < s4_r.qy) ? s4_r.py : s4_r.qy;
    hi_c[1] = (s4_r.py < s4_r.qy) ? s4_r.qy : s4_r.py;
    lo_c[2] = (s4_r.rx < s4_r.sx) ? s4_r.rx : s4_r.sx;
    hi_c[2] = (s4_r.rx < s4_r.sx) ? s4_r.sx : s4_r.rx;
    lo_c[3] = (s4_r.ry < s4_r.sy) ? s4_r.ry : s4_r.sy;
    hi_c[3] = (s4_r.ry < s4_r.sy) ? s4_r.sy : s4_r.ry;
  end

  assign dens = $signed({1'b0, den5_r});

  // Boxes 0 and 2 bound x, boxes 1 and 3 bound y.
  assign inbox = (bl_r[0] <= nx6_r) && (nx6_r <= bh_r[0]) &&
                 (bl_r[1] <= ny6_r) && (ny6_r <= bh_r[1]) &&
                 (bl_r[2] <= nx6_r) && (nx6_r <= bh_r[2]) &&
                 (bl_r[3] <= ny6_r) && (ny6_r <= bh_r[3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[5:0], in_seg.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r   <= c0;
      a1_1_r <= AW'(c0.py) - AW'(c0.qy);
      b1_1_r <= AW'(c0.qx) - AW'(c0.px);
      a2_1_r <= AW'(c0.ry) - AW'(c0.sy);
      b2_1_r <= AW'(c0.sx) - AW'(c0.rx);
      pp0_r  <= c0.px * c0.qy;
      pp1_r  <= c0.qx * c0.py;
      pp2_r  <= c0.rx * c0.sy;
      pp3_r  <= c0.sx * c0.ry;

      s2_r   <= s1_r;
      a1_2_r <= a1_1_r;
      b1_2_r <= b1_1_r;
      a2_2_r <= a2_1_r;
      b2_2_r <= b2_1_r;
      c1_r   <= CW2'(pp0_r) - CW2'(pp1_r);
      c2_r   <= CW2'(pp2_r) - CW2'(pp3_r);

      s3_r <= s2_r;
      m0_r <= a1_2_r * b2_2_r;
      m1_r <= b1_2_r * a2_2_r;
      m2_r <= b1_2_r * c2_r;
      m3_r <= c1_r * b2_2_r;
      m4_r <= c1_r * a2_2_r;
      m5_r <= a1_2_r * c2_r;

      s4_r <= s3_r;
      d_r  <= DW'(m0_r) - DW'(m1_r);
      dx_r <= DXW'(m2_r) - DXW'(m3_r);
      dy_r <= DXW'(m4_r) - DXW'(m5_r);

      nx5_r   <= neg ? -dxw : dxw;
      ny5_r   <= neg ? -dyw : dyw;
      den5_r  <= neg ? DW'(-d_r) : DW'(d_r);
      par5_r  <= d_r == '0;
      coin5_r <= (dx_r == '0) && (dy_r == '0);
      for (int k = 0; k < 4; k++) begin
        lo_r[k] <= lo_c[k];
        hi_r[k] <= hi_c[k];
      end

      for (int k = 0; k < 4; k++) begin
        bl_r[k] <= lo_r[k] * dens;
        bh_r[k] <= hi_r[k] * dens;
      end
      nx6_r   <= nx5_r;
      ny6_r   <= ny5_r;
      den6_r  <= den5_r;
      par6_r  <= par5_r;
      coin6_r <= coin5_r;

      res_r.hit      <= par6_r ? coin6_r : inbox;
      res_r.parallel <= par6_r;
      res_r.num_x    <= nx6_r;
      res_r.num_y    <= ny6_r;
      res_r.den      <= den6_r;
    end
  end

endmodule

[rtl/sit_fifo.sv]
// Short queue between the front end and the divider back end.
`timescale 1ns / 1ps
module sit_fifo import sit_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  mid_t       wr_data,
  input  logic       pop,
  output mid_t       rd_data,
  output fifo_stat_t stat
);

  mid_t                 mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]     cnt_r;

  assign stat.full  = cnt_r == (FIFO_AW+1)'(FIFO_DEPTH);
  assign stat.empty = cnt_r == '0;
  assign rd_data    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_data;
  end

endmodule

[rtl/sit_back.sv]
// Back end: pipelined restoring dividers for the Q-format crossing point, then rounding.
`timescale 1ns / 1ps
module sit_back import sit_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  mid_t      q_data,
  output logic      q_pop,
  sit_out_if.source out_res
);

  typedef struct packed {
    logic [DW-1:0] rem_x;
    logic [QW-1:0] nq_x;
    logic [DW-1:0] rem_y;
    logic [QW-1:0] nq_y;
    logic          neg_x;
    logic          neg_y;
    logic [DW-1:0] den;
    logic          parallel;
    logic          hit;
  } div_t;

  localparam logic [QW:0] LIM_POS = (QW+1)'((64'd1 << (OUT_W-1)) - 64'd1);
  localparam logic [QW:0] LIM_NEG = (QW+1)'(64'd1 << (OUT_W-1));

  logic [QW:0]             vld_r;
  div_t                    st_r [QW+1];
  div_t                    ld;
  logic                    adv;
  logic                    out_v_r;
  logic                    hit_r, par_r, sat_r;
  logic signed [OUT_W-1:0] fx_r, fy_r;
  logic [NW-1:0]           mag_x, mag_y;
  logic [OUT_W-1:0]        fx_c, fy_c;
  logic                    satx_c, saty_c;

  // One quotient bit per stage; remainder stays below a nonzero divisor.
  function automatic void div_bit(input logic [DW-1:0] rem, input logic [QW-1:0] nq,
                                  input logic [DW-1:0] den,
                                  output logic [DW-1:0] rem_o, output logic [QW-1:0] nq_o);
    logic [DW:0] t;
    logic        ge;
    t     = {rem, nq[QW-1]};
    ge    = t >= {1'b0, den};
    rem_o = ge ? DW'(t - {1'b0, den}) : DW'(t);
    nq_o  = {nq[QW-2:0], ge};
  endfunction

  function automatic div_t div_step(input div_t s);
    div_t o;
    o = s;
    div_bit(s.rem_x, s.nq_x, s.den, o.rem_x, o.nq_x);
    div_bit(s.rem_y, s.nq_y, s.den, o.rem_y, o.nq_y);
    return o;
  endfunction

  // Round half away from zero on the magnitude, clamp, restore sign.
  function automatic void finish(input logic [QW-1:0] q, input logic [DW-1:0] rem,
                                 input logic [DW-1:0] den, input logic neg,
                                 output logic [OUT_W-1:0] val, output logic sat);
    logic [QW:0] qr;
    logic [QW:0] lim;
    logic [QW:0] v;
    qr  = (QW+1)'(q) + (QW+1)'({rem, 1'b0} >= {1'b0, den});
    lim = neg ? LIM_NEG : LIM_POS;
    sat = qr > lim;
    v   = sat ? lim : qr;
    val = neg ? OUT_W'(-v[OUT_W-1:0]) : v[OUT_W-1:0];
  endfunction

  assign mag_x = q_data.num_x[NW-1] ? NW'(-q_data.num_x) : NW'(q_data.num_x);
  assign mag_y = q_data.num_y[NW-1] ? NW'(-q_data.num_y) : NW'(q_data.num_y);

  always_comb begin
    ld.rem_x    = '0;
    ld.nq_x     = QW'(mag_x) << FRAC_BITS;
    ld.rem_y    = '0;
    ld.nq_y     = QW'(mag_y) << FRAC_BITS;
    ld.neg_x    = q_data.num_x[NW-1];
    ld.neg_y    = q_data.num_y[NW-1];
    ld.den      = q_data.den;
    ld.parallel = q_data.parallel;
    ld.hit      = q_data.hit;
  end

  always_comb begin
    finish(st_r[QW].nq_x, st_r[QW].rem_x, st_r[QW].den, st_r[QW].neg_x, fx_c, satx_c);
    finish(st_r[QW].nq_y, st_r[QW].rem_y, st_r[QW].den, st_r[QW].neg_y, fy_c, saty_c);
  end

  assign adv   = !out_v_r || out_res.ready;
  assign q_pop = adv && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      vld_r   <= {vld_r[QW-1:0], q_pop};
      out_v_r <= vld_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0] <= ld;
      for (int k = 1; k <= QW; k++) begin
        st_r[k] <= div_step(st_r[k-1]);
      end
      hit_r <= st_r[QW].hit;
      par_r <= st_r[QW].parallel;
      // a zero divisor runs through harmlessly; parallel pairs report zero
      fx_r  <= st_r[QW].parallel ? '0 : fx_c;
      fy_r  <= st_r[QW].parallel ? '0 : fy_c;
      sat_r <= !st_r[QW].parallel && (satx_c || saty_c);
    end
  end

  assign out_res.valid           = out_v_r;
  assign out_res.hit             = hit_r;
  assign out_res.lines_parallel  = par_r;
  assign out_res.cross_x         = fx_r;
  assign out_res.cross_y         = fy_r;
  assign out_res.point_saturated = sat_r;

endmodule

[rtl/segment_intersection_test.sv]
// Segment pair intersection test: Cramer solve, exact box check, Q-format crossing point.
// Path from input transaction to result: 7 front stages, queue, 60 divider
//   stages at one quotient bit each, rounding and output register.
// Throughput: one pair per cycle unless the output stalls, set by the fully pipelined dividers and multipliers.
// Reset: synchronous active-low rst_n empties the pipelines and the 4-entry queue.
`timescale 1ns / 1ps
module segment_intersection_test import sit_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  sit_in_if.sink    in_seg,
  sit_out_if.source out_res
);

  logic       fifo_push, fifo_pop;
  mid_t       fifo_wr, fifo_rd;
  fifo_stat_t fifo_st;

  sit_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_seg (in_seg),
    .q_full (fifo_st.full),
    .q_push (fifo_push),
    .q_data (fifo_wr)
  );

  sit_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (fifo_push),
    .wr_data (fifo_wr),
    .pop     (fifo_pop),
    .rd_data (fifo_rd),
    .stat    (fifo_st)
  );

  sit_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (fifo_st.empty),
    .q_data  (fifo_rd),
    .q_pop   (fifo_pop),
    .out_res (out_res)
  );

  a_par_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && out_res.lines_parallel |->
      out_res.cross_x == '0 && out_res.cross_y == '0 && !out_res.point_saturated)
    else $error("parallel result carries a crossing point");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_push |-> !fifo_st.full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_pop |-> !fifo_st.empty)
    else $error("queue read while empty");

  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_push && !fifo_pop |=> !fifo_st.empty)
    else $error("queue lost a transaction");

endmodule
